### sv/foac_pkg.sv
`timescale 1ns / 1ps
// foac_pkg: widths, constants, register indexes, rule table and divider
// request/response types for the fuzzy obstacle avoidance controller.
// No dependencies.
package foac_pkg;

  localparam int unsigned DIST_W     = 13;
  localparam int unsigned SPEED_W    = 10;
  localparam int unsigned MEM_W      = 16;  // Q1.15 membership, 1.0 = 32768
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned NUM_RULES  = 27;
  localparam int unsigned RULE_IDX_W = 5;
  localparam int unsigned ACC_W      = 27;  // sum of three 16x10 products
  localparam int unsigned PROD_W     = MEM_W + SPEED_W;
  localparam int unsigned DEN_W      = 17;  // divisor / partial remainder
  localparam int unsigned LOWB_W     = 16;  // dividend bits shifted in
  localparam int unsigned CNT_W      = 5;

  localparam logic [DIST_W-1:0] NO_ECHO = 13'd5000;
  localparam logic [MEM_W-1:0]  ONE_Q15 = 16'd32768;

  localparam logic [DIST_W-1:0]  RST_LOW_FULL_EDGE  = 13'd600;
  localparam logic [DIST_W-1:0]  RST_MID_PEAK       = 13'd1000;
  localparam logic [DIST_W-1:0]  RST_HIGH_FULL_EDGE = 13'd1400;
  localparam logic [SPEED_W-1:0] RST_SPEED_LOW      = 10'd100;
  localparam logic [SPEED_W-1:0] RST_SPEED_MEDIUM   = 10'd150;
  localparam logic [SPEED_W-1:0] RST_SPEED_HIGH     = 10'd200;

  localparam logic [CNT_W-1:0] MEM_DIV_BITS = 5'd16;
  localparam logic [CNT_W-1:0] SPD_DIV_BITS = 5'd10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOW_FULL_EDGE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MID_PEAK       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_FULL_EDGE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LOW      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_MEDIUM   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_HIGH     = 3'd5;

  typedef enum logic [1:0] {
    LBL_LOW,
    LBL_MED,
    LBL_HIGH
  } label_e;

  typedef struct packed {
    label_e ant_l;
    label_e ant_f;
    label_e ant_r;
    label_e con_l;
    label_e con_r;
  } rule_t;

  typedef struct packed {
    logic              start;
    logic [DEN_W-1:0]  rem0;   // must be below den
    logic [LOWB_W-1:0] low;    // dividend bits, MSB first
    logic [DEN_W-1:0]  den;
    logic [CNT_W-1:0]  nbits;  // quotient bits to produce
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [LOWB_W-1:0] quot;
    logic              rem_nz;
  } div_rsp_t;

  // rule base: left, front, right antecedents; left, right wheel consequents
  function automatic rule_t rule_at(input logic [RULE_IDX_W-1:0] k);
    rule_t r;
    case (k)
      5'd0:  r = '{LBL_LOW,  LBL_LOW,  LBL_LOW,  LBL_LOW,  LBL_LOW};
      5'd1:  r = '{LBL_LOW,  LBL_MED,  LBL_LOW,  LBL_LOW,  LBL_LOW};
      5'd2:  r = '{LBL_LOW,  LBL_HIGH, LBL_LOW,  LBL_LOW,  LBL_LOW};
      5'd3:  r = '{LBL_MED,  LBL_LOW,  LBL_LOW,  LBL_LOW,  LBL_HIGH};
      5'd4:  r = '{LBL_HIGH, LBL_LOW,  LBL_LOW,  LBL_LOW,  LBL_HIGH};
      5'd5:  r = '{LBL_MED,  LBL_MED,  LBL_LOW,  LBL_LOW,  LBL_HIGH};
      5'd6:  r = '{LBL_HIGH, LBL_MED,  LBL_LOW,  LBL_LOW,  LBL_HIGH};
      5'd7:  r = '{LBL_MED,  LBL_HIGH, LBL_LOW,  LBL_LOW,  LBL_HIGH};
      5'd8:  r = '{LBL_HIGH, LBL_HIGH, LBL_LOW,  LBL_LOW,  LBL_HIGH};
      5'd9:  r = '{LBL_HIGH, LBL_LOW,  LBL_MED,  LBL_LOW,  LBL_HIGH};
      5'd10: r = '{LBL_HIGH, LBL_LOW,  LBL_HIGH, LBL_HIGH, LBL_LOW};
      5'd11: r = '{LBL_MED,  LBL_LOW,  LBL_MED,  LBL_HIGH, LBL_LOW};
      5'd12: r = '{LBL_MED,  LBL_LOW,  LBL_HIGH, LBL_HIGH, LBL_LOW};
      5'd13: r = '{LBL_LOW,  LBL_LOW,  LBL_MED,  LBL_HIGH, LBL_LOW};
      5'd14: r = '{LBL_LOW,  LBL_LOW,  LBL_HIGH, LBL_HIGH, LBL_LOW};
      5'd15: r = '{LBL_LOW,  LBL_MED,  LBL_MED,  LBL_HIGH, LBL_LOW};
      5'd16: r = '{LBL_LOW,  LBL_MED,  LBL_HIGH, LBL_HIGH, LBL_LOW};
      5'd17: r = '{LBL_LOW,  LBL_HIGH, LBL_MED,  LBL_HIGH, LBL_LOW};
      5'd18: r = '{LBL_LOW,  LBL_HIGH, LBL_HIGH, LBL_HIGH, LBL_LOW};
      5'd19: r = '{LBL_MED,  LBL_MED,  LBL_MED,  LBL_MED,  LBL_MED};
      5'd20: r = '{LBL_MED,  LBL_MED,  LBL_HIGH, LBL_MED,  LBL_MED};
      5'd21: r = '{LBL_MED,  LBL_HIGH, LBL_MED,  LBL_MED,  LBL_MED};
      5'd22: r = '{LBL_HIGH, LBL_MED,  LBL_MED,  LBL_MED,  LBL_MED};
      5'd23: r = '{LBL_MED,  LBL_HIGH, LBL_HIGH, LBL_MED,  LBL_MED};
      5'd24: r = '{LBL_HIGH, LBL_HIGH, LBL_MED,  LBL_MED,  LBL_MED};
      5'd25: r = '{LBL_HIGH, LBL_MED,  LBL_HIGH, LBL_MED,  LBL_MED};
      5'd26: r = '{LBL_HIGH, LBL_HIGH, LBL_HIGH, LBL_MED,  LBL_MED};
      default: r = '{LBL_LOW, LBL_LOW, LBL_LOW, LBL_LOW, LBL_LOW};
    endcase
    return r;
  endfunction

endpackage

### sv/foac_if.sv
`timescale 1ns / 1ps
// foac_in_if / foac_out_if: valid/ready channels for sonar items and wheel
// speed items. Depends on foac_pkg.
interface foac_in_if import foac_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] left_range;
  logic [DIST_W-1:0] front_left_range;
  logic [DIST_W-1:0] front_right_range;
  logic [DIST_W-1:0] right_range;

  modport source (
    output valid, left_range, front_left_range, front_right_range, right_range,
    input  ready
  );
  modport sink (
    input  valid, left_range, front_left_range, front_right_range, right_range,
    output ready
  );
endinterface

interface foac_out_if import foac_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] left_speed;
  logic [SPEED_W-1:0] right_speed;

  modport source (
    output valid, left_speed, right_speed,
    input  ready
  );
  modport sink (
    input  valid, left_speed, right_speed,
    output ready
  );
endinterface

### sv/foac_div.sv
`timescale 1ns / 1ps
// foac_div: shared restoring divider, one quotient bit per cycle.
// Depends on foac_pkg.
module foac_div import foac_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DEN_W-1:0]  rem_q, den_q;
  logic [LOWB_W-1:0] low_q, quot_q;

  logic [DEN_W:0] trial;
  logic           ge;
  logic [DEN_W:0] rem_d;

  assign trial = {rem_q, low_q[LOWB_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign rem_d = ge ? (trial - {1'b0, den_q}) : trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1)) && !req_i.start;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.nbits;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.rem0;
      low_q  <= req_i.low;
      den_q  <= req_i.den;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d[DEN_W-1:0];  // below den, fits
      low_q  <= {low_q[LOWB_W-2:0], 1'b0};
      quot_q <= {quot_q[LOWB_W-2:0], ge};
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.quot   = quot_q;
  assign rsp_o.rem_nz = |rem_q;

endmodule

### sv/fuzzy_obstacle_avoidance_controller.sv
`timescale 1ns / 1ps
// fuzzy_obstacle_avoidance_controller: top level, sequencer around one shared
// divider (foac_div). Depends on foac_pkg, foac_in_if/foac_out_if, foac_div.
//
//  channel   dir  handshake     payload
//  in_i      in   valid/ready   left_range, front_left_range,
//                               front_right_range, right_range (13b each)
//  out_o     out  valid/ready   left_speed, right_speed (10b each)
//  cfg       in   cfg_we_i      cfg_idx_i (3b), cfg_wdata_i (13b)
//
// Sequence: the shared divider carries three 16-bit membership divisions,
//   then the 27 rules are evaluated in turn, and per wheel the three
//   weight * center products are accumulated and a 10-bit division follows
//   (skipped when no rule fires for that wheel). A new item is accepted
//   only after the last result has gone to the output register.
// Reset: async, active low; config registers back to their defaults, last front 0.
// Stalls: in_i.ready is high only while idle; a finished result waits in the
//   sequencer if the output register is still full.
module fuzzy_obstacle_avoidance_controller import foac_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  foac_in_if.sink               in_i,
  foac_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MSTART = 3'd1;  // launch membership division
  localparam logic [2:0] ST_MWAIT  = 3'd2;
  localparam logic [2:0] ST_RULE   = 3'd3;  // one rule per cycle
  localparam logic [2:0] ST_MUL    = 3'd4;  // weight * center accumulate
  localparam logic [2:0] ST_DSTART = 3'd5;  // launch center-average division
  localparam logic [2:0] ST_DWAIT  = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;  // hand result to output register

  logic [2:0] state_q, state_d;

  // ---------------- configuration ----------------
  logic [DIST_W-1:0]  lfe_q, mp_q, hfe_q;
  logic [SPEED_W-1:0] spd_lo_q, spd_md_q, spd_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfe_q    <= RST_LOW_FULL_EDGE;
      mp_q     <= RST_MID_PEAK;
      hfe_q    <= RST_HIGH_FULL_EDGE;
      spd_lo_q <= RST_SPEED_LOW;
      spd_md_q <= RST_SPEED_MEDIUM;
      spd_hi_q <= RST_SPEED_HIGH;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LOW_FULL_EDGE:  lfe_q    <= cfg_wdata_i[DIST_W-1:0];
        REG_MID_PEAK:       mp_q     <= cfg_wdata_i[DIST_W-1:0];
        REG_HIGH_FULL_EDGE: hfe_q    <= cfg_wdata_i[DIST_W-1:0];
        REG_SPEED_LOW:      spd_lo_q <= cfg_wdata_i[SPEED_W-1:0];
        REG_SPEED_MEDIUM:   spd_md_q <= cfg_wdata_i[SPEED_W-1:0];
        REG_SPEED_HIGH:     spd_hi_q <= cfg_wdata_i[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- front fusion (at accept) ----------------
  logic              in_acc;
  logic [DIST_W-1:0] fl, fr, front_fused;
  logic              echo_l, echo_r;
  logic [DIST_W:0]   fl_x2, fr_x2, front_sum;
  logic [DIST_W-1:0] last_front_q;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  assign fl        = in_i.front_left_range;
  assign fr        = in_i.front_right_range;
  assign echo_l    = fl < NO_ECHO;
  assign echo_r    = fr < NO_ECHO;
  assign fl_x2     = {fl, 1'b0};
  assign fr_x2     = {fr, 1'b0};
  assign front_sum = {1'b0, fl} + {1'b0, fr};

  always_comb begin
    if (echo_l && !echo_r) begin
      front_fused = fl;
    end else if (!echo_l && echo_r) begin
      front_fused = fr;
    end else if (!echo_l && !echo_r) begin
      front_fused = last_front_q;  // no echo at all: hold
    end else if ({1'b0, fr} >= fl_x2) begin
      front_fused = fl;            // left front tested first
    end else if ({1'b0, fl} >= fr_x2) begin
      front_fused = fr;
    end else begin
      front_fused = front_sum[DIST_W:1];
    end
  end

  // ---------------- datapath registers ----------------
  logic [DIST_W-1:0]     dist_q [3];   // left, front, right
  logic [MEM_W-1:0]      memb_q [3][3];
  logic [MEM_W-1:0]      lw_q [3];
  logic [MEM_W-1:0]      rw_q [3];
  logic [ACC_W-1:0]      acc_q;
  logic [SPEED_W-1:0]    res_l_q, res_r_q;
  logic [1:0]            didx_q;
  logic [RULE_IDX_W-1:0] rule_q;
  logic                  wheel_q;      // 0 left, 1 right
  logic [1:0]            term_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  foac_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---------------- fuzzification of dist_q[didx_q] ----------------
  // One division per distance: the LOW/MED ratios on the rising side and the
  // MED/HIGH ratios on the falling side share a denominator and their
  // numerators sum to it, so the partner is 1.0 - q - (remainder != 0).
  logic [DIST_W-1:0] d, m_num, m_den;
  logic              case_r, case_f;
  logic [MEM_W-1:0]  q_ratio, q_comp, m_low, m_med, m_high;

  assign d      = dist_q[didx_q];
  assign case_r = (d > lfe_q) && (d <= mp_q);
  assign case_f = (d > mp_q) && (d < hfe_q);
  assign m_num  = case_r ? (d - lfe_q) : (hfe_q - d);
  assign m_den  = case_r ? (mp_q - lfe_q) : (hfe_q - mp_q);

  assign q_ratio = div_rsp.quot;
  assign q_comp  = ONE_Q15 - q_ratio - MEM_W'(div_rsp.rem_nz);

  always_comb begin
    if (d <= lfe_q) begin
      m_low = ONE_Q15;
    end else if (case_r && (d < mp_q)) begin
      m_low = q_comp;
    end else begin
      m_low = '0;
    end

    if (case_r) begin
      m_med = (d < hfe_q) ? q_ratio : '0;
    end else if (case_f) begin
      m_med = (d > lfe_q) ? q_ratio : '0;
    end else begin
      m_med = '0;
    end

    if (case_f) begin
      m_high = q_comp;
    end else if (d <= mp_q) begin
      m_high = '0;
    end else begin
      m_high = ONE_Q15;
    end
  end

  // ---------------- rule evaluation ----------------
  rule_t            rl;
  logic [MEM_W-1:0] ma, mb, mc, wmin_ab, wmin;
  logic             fire;
  label_e           lw_idx, rw_idx;
  logic [MEM_W-1:0] lw_rd, rw_rd;
  logic             upd_l, upd_r;

  assign rl      = rule_at(rule_q);
  assign ma      = memb_q[0][rl.ant_l];
  assign mb      = memb_q[1][rl.ant_f];
  assign mc      = memb_q[2][rl.ant_r];
  assign fire    = (ma != '0) && (mb != '0) && (mc != '0);
  assign wmin_ab = (ma < mb) ? ma : mb;
  assign wmin    = (mc < wmin_ab) ? mc : wmin_ab;

  // one read index per weight bank: rule consequent, else the MAC term
  assign lw_idx = (state_q == ST_RULE) ? rl.con_l : label_e'(term_q);
  assign rw_idx = (state_q == ST_RULE) ? rl.con_r : label_e'(term_q);
  assign lw_rd  = lw_q[lw_idx];
  assign rw_rd  = rw_q[rw_idx];

  // each label keeps the smallest nonzero strength
  assign upd_l = fire && ((lw_rd == '0) || (lw_rd > wmin));
  assign upd_r = fire && ((rw_rd == '0) || (rw_rd > wmin));

  // ---------------- defuzzification ----------------
  logic [MEM_W-1:0]   w_sel;
  logic [SPEED_W-1:0] c_sel;
  logic [PROD_W-1:0]  prod;
  logic [DEN_W-1:0]   wsum;

  assign w_sel = wheel_q ? rw_rd : lw_rd;

  always_comb begin
    case (term_q)
      2'd0:    c_sel = spd_lo_q;
      2'd1:    c_sel = spd_md_q;
      default: c_sel = spd_hi_q;
    endcase
  end

  assign prod = w_sel * c_sel;
  assign wsum = wheel_q
              ? (DEN_W'(rw_q[0]) + DEN_W'(rw_q[1]) + DEN_W'(rw_q[2]))
              : (DEN_W'(lw_q[0]) + DEN_W'(lw_q[1]) + DEN_W'(lw_q[2]));

  // ---------------- divider request mux ----------------
  always_comb begin
    div_req = '0;
    if (state_q == ST_MSTART) begin
      // num*2^15/den as (num>>1)*2^16 + num[0]*2^15, num <= den
      div_req.start = 1'b1;
      div_req.rem0  = DEN_W'(m_num >> 1);
      div_req.low   = {m_num[0], {(LOWB_W-1){1'b0}}};
      div_req.den   = DEN_W'(m_den);
      div_req.nbits = MEM_DIV_BITS;
    end else if (state_q == ST_DSTART) begin
      // quotient below 1024, so acc>>10 is already below the weight sum
      div_req.start = (wsum != '0);
      div_req.rem0  = acc_q[ACC_W-1:SPEED_W];
      div_req.low   = {acc_q[SPEED_W-1:0], {(LOWB_W-SPEED_W){1'b0}}};
      div_req.den   = wsum;
      div_req.nbits = SPD_DIV_BITS;
    end
  end

  // ---------------- output register ----------------
  logic               out_valid_q;
  logic [SPEED_W-1:0] out_l_q, out_r_q;
  logic               out_load;

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  assign out_o.valid       = out_valid_q;
  assign out_o.left_speed  = out_l_q;
  assign out_o.right_speed = out_r_q;

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_acc) state_d = ST_MSTART;
      ST_MSTART: state_d = ST_MWAIT;
      ST_MWAIT: begin
        if (div_rsp.done) begin
          state_d = (didx_q == 2'd2) ? ST_RULE : ST_MSTART;
        end
      end
      ST_RULE: begin
        if (rule_q == RULE_IDX_W'(NUM_RULES - 1)) state_d = ST_MUL;
      end
      ST_MUL:    if (term_q == 2'd2) state_d = ST_DSTART;
      ST_DSTART: begin
        if (wsum != '0) begin
          state_d = ST_DWAIT;
        end else begin
          state_d = wheel_q ? ST_DONE : ST_MUL;
        end
      end
      ST_DWAIT: begin
        if (div_rsp.done) state_d = wheel_q ? ST_DONE : ST_MUL;
      end
      ST_DONE:   if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      last_front_q <= '0;
      out_valid_q  <= 1'b0;
      didx_q       <= '0;
      rule_q       <= '0;
      wheel_q      <= 1'b0;
      term_q       <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        last_front_q <= front_fused;
        didx_q       <= '0;
      end
      if ((state_q == ST_MWAIT) && div_rsp.done) begin
        didx_q <= didx_q + 2'd1;
      end
      if (state_q == ST_MWAIT) begin
        rule_q <= '0;
      end else if (state_q == ST_RULE) begin
        rule_q <= rule_q + RULE_IDX_W'(1);
      end
      if (state_q == ST_RULE) begin
        wheel_q <= 1'b0;
        term_q  <= '0;
      end else if (state_q == ST_MUL) begin
        term_q <= term_q + 2'd1;
      end else if ((state_q == ST_DSTART) || (state_q == ST_DWAIT)) begin
        term_q <= '0;
        if (state_d == ST_MUL) wheel_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dist_q[0] <= in_i.left_range;
      dist_q[1] <= front_fused;
      dist_q[2] <= in_i.right_range;
      lw_q      <= '{default: '0};
      rw_q      <= '{default: '0};
    end
    if ((state_q == ST_MWAIT) && div_rsp.done) begin
      memb_q[didx_q][LBL_LOW]  <= m_low;
      memb_q[didx_q][LBL_MED]  <= m_med;
      memb_q[didx_q][LBL_HIGH] <= m_high;
    end
    if (state_q == ST_RULE) begin
      if (upd_l) lw_q[lw_idx] <= wmin;
      if (upd_r) rw_q[rw_idx] <= wmin;
    end
    if ((state_q == ST_RULE) || (state_q == ST_DSTART) || (state_q == ST_DWAIT)) begin
      acc_q <= '0;
    end else if (state_q == ST_MUL) begin
      acc_q <= acc_q + ACC_W'(prod);
    end
    // no rule fired for this wheel: speed 0
    if ((state_q == ST_DSTART) && (wsum == '0)) begin
      if (wheel_q) res_r_q <= '0;
      else         res_l_q <= '0;
    end
    if ((state_q == ST_DWAIT) && div_rsp.done) begin
      if (wheel_q) res_r_q <= div_rsp.quot[SPEED_W-1:0];
      else         res_l_q <= div_rsp.quot[SPEED_W-1:0];
    end
    if (out_load) begin
      out_l_q <= res_l_q;
      out_r_q <= res_r_q;
    end
  end

endmodule

### sv/foac_checker.sv
`timescale 1ns / 1ps
// foac_checker: port-level assertions for the controller, and the bind that
// attaches them. Depends on foac_pkg and fuzzy_obstacle_avoidance_controller.
module foac_checker import foac_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [SPEED_W-1:0] out_left_i,
  input logic [SPEED_W-1:0] out_right_i
);

  logic       in_acc, out_acc;
  logic [1:0] pend_q;  // items accepted but not yet delivered

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 2'd1;
    end else if (!in_acc && out_acc) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  // one item computing and one in the output register at most
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two items in flight");

  // no result without an item behind it
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (pend_q != 2'd0))
    else $error("result shown with no item outstanding");

  // one item at a time in the sequencer
  a_busy_after_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("input ready right after accepting an item");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_left_i) && $stable(out_right_i)))
    else $error("stalled result changed or dropped");

endmodule

bind fuzzy_obstacle_avoidance_controller foac_checker u_foac_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_left_i  (out_o.left_speed),
  .out_right_i (out_o.right_speed)
);

### sim/tb_fuzzy_obstacle_avoidance_controller.sv
`timescale 1ns / 1ps
// tb_fuzzy_obstacle_avoidance_controller: self-checking bench with its own wheel speed
// predictor, random idling on both channels and a long output hold-off.
// Depends on foac_pkg, foac_in_if / foac_out_if and the DUT.
module tb_fuzzy_obstacle_avoidance_controller;
  import foac_pkg::*;

  // ---------------------------------------------------------------------------
  // Bench constants
  // ---------------------------------------------------------------------------
  localparam int unsigned ECHO_LIMIT     = 5000;   // front reading at or above: no echo
  localparam bit [15:0]   Q15_ONE        = 16'd32768;
  localparam int unsigned WATCHDOG_LIMIT = 5000;   // cycles with no item moving
  localparam int unsigned DRAIN_CYCLES   = 120;    // one item latency plus margin
  localparam int unsigned PARK_CYCLES    = 700;    // long output hold-off
  localparam int unsigned N_PHASES       = 10;     // written register sets
  localparam int unsigned BATCH          = 160;    // random items per written set

  typedef struct packed {
    bit [DIST_W-1:0] left;
    bit [DIST_W-1:0] front_left;
    bit [DIST_W-1:0] front_right;
    bit [DIST_W-1:0] right;
  } sonar_t;

  typedef struct packed {
    logic [SPEED_W-1:0] left;
    logic [SPEED_W-1:0] right;
  } speed_t;

  // Memberships or label strengths, indexed by label.
  typedef bit [2:0][15:0] grades_t;

  // One rule: left, front, right antecedents, then left and right wheel labels.
  typedef struct packed {
    label_e al;
    label_e af;
    label_e ar;
    label_e cl;
    label_e cr;
  } fuzzy_rule_t;

  localparam fuzzy_rule_t RULEBOOK [NUM_RULES] = '{
    '{LBL_LOW,  LBL_LOW,  LBL_LOW,  LBL_LOW,  LBL_LOW },
    '{LBL_LOW,  LBL_MED,  LBL_LOW,  LBL_LOW,  LBL_LOW },
    '{LBL_LOW,  LBL_HIGH, LBL_LOW,  LBL_LOW,  LBL_LOW },
    '{LBL_MED,  LBL_LOW,  LBL_LOW,  LBL_LOW,  LBL_HIGH},
    '{LBL_HIGH, LBL_LOW,  LBL_LOW,  LBL_LOW,  LBL_HIGH},
    '{LBL_MED,  LBL_MED,  LBL_LOW,  LBL_LOW,  LBL_HIGH},
    '{LBL_HIGH, LBL_MED,  LBL_LOW,  LBL_LOW,  LBL_HIGH},
    '{LBL_MED,  LBL_HIGH, LBL_LOW,  LBL_LOW,  LBL_HIGH},
    '{LBL_HIGH, LBL_HIGH, LBL_LOW,  LBL_LOW,  LBL_HIGH},
    '{LBL_HIGH, LBL_LOW,  LBL_MED,  LBL_LOW,  LBL_HIGH},
    '{LBL_HIGH, LBL_LOW,  LBL_HIGH, LBL_HIGH, LBL_LOW },
    '{LBL_MED,  LBL_LOW,  LBL_MED,  LBL_HIGH, LBL_LOW },
    '{LBL_MED,  LBL_LOW,  LBL_HIGH, LBL_HIGH, LBL_LOW },
    '{LBL_LOW,  LBL_LOW,  LBL_MED,  LBL_HIGH, LBL_LOW },
    '{LBL_LOW,  LBL_LOW,  LBL_HIGH, LBL_HIGH, LBL_LOW },
    '{LBL_LOW,  LBL_MED,  LBL_MED,  LBL_HIGH, LBL_LOW },
    '{LBL_LOW,  LBL_MED,  LBL_HIGH, LBL_HIGH, LBL_LOW },
    '{LBL_LOW,  LBL_HIGH, LBL_MED,  LBL_HIGH, LBL_LOW },
    '{LBL_LOW,  LBL_HIGH, LBL_HIGH, LBL_HIGH, LBL_LOW },
    '{LBL_MED,  LBL_MED,  LBL_MED,  LBL_MED,  LBL_MED },
    '{LBL_MED,  LBL_MED,  LBL_HIGH, LBL_MED,  LBL_MED },
    '{LBL_MED,  LBL_HIGH, LBL_MED,  LBL_MED,  LBL_MED },
    '{LBL_HIGH, LBL_MED,  LBL_MED,  LBL_MED,  LBL_MED },
    '{LBL_MED,  LBL_HIGH, LBL_HIGH, LBL_MED,  LBL_MED },
    '{LBL_HIGH, LBL_HIGH, LBL_MED,  LBL_MED,  LBL_MED },
    '{LBL_HIGH, LBL_MED,  LBL_HIGH, LBL_MED,  LBL_MED },
    '{LBL_HIGH, LBL_HIGH, LBL_HIGH, LBL_MED,  LBL_MED }
  };

  // ---------------------------------------------------------------------------
  // Wheel speed scoreboard: keeps its own copy of the registers and of the last
  // fused front distance, predicts the speeds of each accepted sonar item and
  // checks result items against them in order.
  // ---------------------------------------------------------------------------
  class wheel_speed_board;
    bit [DIST_W-1:0]  low_edge;
    bit [DIST_W-1:0]  peak;
    bit [DIST_W-1:0]  high_edge;
    bit [SPEED_W-1:0] center [3];
    bit [DIST_W-1:0]  last_front;
    speed_t           expected_speeds [$];
    int unsigned      n_checked;
    int unsigned      n_errors;

    function new();
      low_edge        = 13'd600;
      peak            = 13'd1000;
      high_edge       = 13'd1400;
      center[LBL_LOW]  = 10'd100;
      center[LBL_MED]  = 10'd150;
      center[LBL_HIGH] = 10'd200;
      last_front      = '0;
      n_checked       = 0;
      n_errors        = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_LOW_FULL_EDGE:  low_edge         = v;
        REG_MID_PEAK:       peak             = v;
        REG_HIGH_FULL_EDGE: high_edge        = v;
        REG_SPEED_LOW:      center[LBL_LOW]  = v[SPEED_W-1:0];
        REG_SPEED_MEDIUM:   center[LBL_MED]  = v[SPEED_W-1:0];
        REG_SPEED_HIGH:     center[LBL_HIGH] = v[SPEED_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_speeds.size();
    endfunction

    // floor(num * 1.0 / den) in Q1.15
    function bit [15:0] q15_ratio(int unsigned num, int unsigned den);
      if (den == 0) return '0;
      return 16'((num << 15) / den);
    endfunction

    function grades_t grade(bit [DIST_W-1:0] d);
      grades_t     g;
      int unsigned a, p, h, x;
      a = low_edge;
      p = peak;
      h = high_edge;
      x = d;
      g = '0;
      if (x <= a) g[LBL_LOW] = Q15_ONE;
      else if (x < p) g[LBL_LOW] = q15_ratio(p - x, p - a);
      if (x > a && x < h) begin
        if (x <= p) g[LBL_MED] = q15_ratio(x - a, p - a);
        else g[LBL_MED] = q15_ratio(h - x, h - p);
      end
      if (x > p) g[LBL_HIGH] = (x < h) ? q15_ratio(x - p, h - p) : Q15_ONE;
      return g;
    endfunction

    function bit [DIST_W-1:0] fuse_front(bit [DIST_W-1:0] fl, bit [DIST_W-1:0] fr);
      bit          echo_l, echo_r;
      int unsigned l, r;
      l = fl;
      r = fr;
      echo_l = l < ECHO_LIMIT;
      echo_r = r < ECHO_LIMIT;
      if (echo_l && !echo_r) return fl;
      if (!echo_l && echo_r) return fr;
      if (!echo_l && !echo_r) return last_front;
      if (r >= 2 * l) return fl;
      if (l >= 2 * r) return fr;
      return DIST_W'((l + r) >> 1);
    endfunction

    function bit [SPEED_W-1:0] center_average(grades_t w);
      int unsigned num, den;
      num = int'(w[LBL_LOW]) * center[LBL_LOW] + int'(w[LBL_MED]) * center[LBL_MED]
          + int'(w[LBL_HIGH]) * center[LBL_HIGH];
      den = int'(w[LBL_LOW]) + int'(w[LBL_MED]) + int'(w[LBL_HIGH]);
      if (den == 0) return '0;
      return SPEED_W'(num / den);
    endfunction

    function speed_t predict_speeds(sonar_t s);
      grades_t         gl, gf, gr, wl, wr;
      bit [15:0]       ga, gb, gc, w;
      bit [DIST_W-1:0] front;
      speed_t          res;
      front      = fuse_front(s.front_left, s.front_right);
      last_front = front;
      gl = grade(s.left);
      gf = grade(front);
      gr = grade(s.right);
      wl = '0;
      wr = '0;
      foreach (RULEBOOK[k]) begin
        ga = gl[RULEBOOK[k].al];
        gb = gf[RULEBOOK[k].af];
        gc = gr[RULEBOOK[k].ar];
        if (ga == 0 || gb == 0 || gc == 0) continue;
        w = (ga < gb) ? ga : gb;
        if (gc < w) w = gc;
        // each label keeps the weakest rule that fired for it
        if (wl[RULEBOOK[k].cl] == 0 || wl[RULEBOOK[k].cl] > w) wl[RULEBOOK[k].cl] = w;
        if (wr[RULEBOOK[k].cr] == 0 || wr[RULEBOOK[k].cr] > w) wr[RULEBOOK[k].cr] = w;
      end
      res.left  = center_average(wl);
      res.right = center_average(wr);
      return res;
    endfunction

    function void note_sonar(sonar_t s);
      expected_speeds.push_back(predict_speeds(s));
    endfunction

    function void check_speed(speed_t got);
      speed_t want;
      if (expected_speeds.size() == 0) begin
        n_errors++;
        $display("%0t: speed item with none expected, actual left %0d right %0d",
                 $time, got.left, got.right);
        return;
      end
      want = expected_speeds.pop_front();
      n_checked++;
      if (got.left !== want.left) begin
        n_errors++;
        $display("%0t: left_speed expected %0d actual %0d", $time, want.left, got.left);
      end
      if (got.right !== want.right) begin
        n_errors++;
        $display("%0t: right_speed expected %0d actual %0d", $time, want.right, got.right);
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset, channels, DUT
  // ---------------------------------------------------------------------------
  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  foac_in_if  sonar_if ();
  foac_out_if speed_if ();

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  fuzzy_obstacle_avoidance_controller i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (sonar_if),
    .out_o       (speed_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  wheel_speed_board sb;
  int unsigned      n_sonar;         // sonar items accepted
  int unsigned      n_parks;         // long hold-offs done by the receiver
  int unsigned      quiet_cycles;    // watchdog count
  int unsigned      park_len;        // hold-off request to the receiver, 0 = none
  bit               source_steady;   // sender offers back to back
  bit               sink_steady;     // receiver never stalls

  // ---------------------------------------------------------------------------
  // Random distance helpers. About half the values sit within a few mm of one
  // of the current membership breakpoints, since that is where the piecewise
  // tests and the Q1.15 ratios are most likely to go wrong.
  // ---------------------------------------------------------------------------
  function automatic bit [DIST_W-1:0] pick_distance();
    int r, v;
    r = $urandom_range(99);
    if (r < 45) begin
      case ($urandom_range(2))
        0:       v = sb.low_edge;
        1:       v = sb.peak;
        default: v = sb.high_edge;
      endcase
      v = v + int'($urandom_range(6)) - 3;
      if (v < 0) v = 0;
    end else if (r < 90) begin
      v = $urandom_range(4999);
    end else begin
      v = $urandom_range(8191);
    end
    return DIST_W'(v);
  endfunction

  // No echo: mostly the nominal 5000, sometimes anything above it.
  function automatic bit [DIST_W-1:0] no_echo_value();
    if ($urandom_range(9) < 7) return DIST_W'(ECHO_LIMIT);
    return DIST_W'($urandom_range(8191, ECHO_LIMIT + 1));
  endfunction

  // Mix of front cases: one or both without echo, pairs right at the
  // "twice as far" boundary, and independent readings (mean or nearer).
  function automatic sonar_t random_sonar();
    sonar_t s;
    int     r, near;
    s.left        = pick_distance();
    s.right       = pick_distance();
    s.front_left  = pick_distance();
    s.front_right = pick_distance();
    r = $urandom_range(99);
    if (r < 15) begin
      s.front_right = no_echo_value();
    end else if (r < 30) begin
      s.front_left = no_echo_value();
    end else if (r < 38) begin
      s.front_left  = no_echo_value();
      s.front_right = no_echo_value();
    end else if (r < 55) begin
      near = $urandom_range(2499);
      s.front_left = DIST_W'(near);
      near = 2 * near + int'($urandom_range(2)) - 1;
      s.front_right = DIST_W'((near < 0) ? 0 : near);
      if ($urandom_range(1) == 1) {s.front_left, s.front_right} = {s.front_right, s.front_left};
    end
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: offer one item, hold it until accepted, then maybe a gap.
  // Gaps: mostly none, some short, a few long enough to land anywhere in the
  // processing window of the block.
  // ---------------------------------------------------------------------------
  task automatic drive_sonar(sonar_t s);
    int unsigned gap, r;
    sonar_if.valid             <= 1'b1;
    sonar_if.left_range        <= s.left;
    sonar_if.front_left_range  <= s.front_left;
    sonar_if.front_right_range <= s.front_right;
    sonar_if.right_range       <= s.right;
    @(posedge clk_i);
    while (sonar_if.ready !== 1'b1) @(posedge clk_i);
    sb.note_sonar(s);
    n_sonar++;
    gap = 0;
    if (!source_steady) begin
      r = $urandom_range(99);
      if (r >= 95) gap = $urandom_range(300, 131);
      else if (r >= 85) gap = $urandom_range(130, 20);
      else if (r >= 60) gap = $urandom_range(8, 1);
    end
    if (gap != 0) begin
      sonar_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic random_sonar_batch(int unsigned n);
    repeat (n) drive_sonar(random_sonar());
  endtask

  // Stop offering and wait for every predicted speed item to come back.
  task automatic drain_speeds();
    sonar_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Register sets, written only while the block is idle. Fixed sets cover
  // the extremes and the out-of-order breakpoints; the rest are random.
  task automatic apply_setting(int unsigned phase);
    int unsigned           e [$];
    int unsigned           a, p, h, sl, sm, sh;
    logic [CFG_IDX_W-1:0]  idx_list [6];
    logic [CFG_DATA_W-1:0] vals [6];
    case (phase)
      1:       begin a = 600;  p = 1000; h = 1400; sl = 0;    sm = 500;  sh = 1000; end
      2:       begin a = 0;    p = 0;    h = 0;    sl = 0;    sm = 0;    sh = 0;    end
      3:       begin a = 5000; p = 5000; h = 5000; sl = 1000; sm = 1000; sh = 1000; end
      4:       begin a = 600;  p = 1000; h = 900;  sl = 100;  sm = 150;  sh = 200;  end
      5:       begin a = 2000; p = 1000; h = 3000; sl = 1000; sm = 0;    sh = 500;  end
      6:       begin a = 1000; p = 1000; h = 2000; sl = 200;  sm = 100;  sh = 900;  end
      default: begin
        repeat (3) e.push_back($urandom_range(5000));
        if (phase != N_PHASES) e.sort();   // last set keeps random order
        a  = e[0];
        p  = e[1];
        h  = e[2];
        sl = $urandom_range(1000);
        sm = $urandom_range(1000);
        sh = $urandom_range(1000);
      end
    endcase
    idx_list = '{REG_LOW_FULL_EDGE, REG_MID_PEAK, REG_HIGH_FULL_EDGE,
                 REG_SPEED_LOW, REG_SPEED_MEDIUM, REG_SPEED_HIGH};
    vals = '{CFG_DATA_W'(a), CFG_DATA_W'(p), CFG_DATA_W'(h),
             CFG_DATA_W'(sl), CFG_DATA_W'(sm), CFG_DATA_W'(sh)};
    for (int i = 0; i < 6; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx_list[i];
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      sb.set_reg(idx_list[i], vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: per cycle ready, with short and occasional long stalls, steady
  // stretches when asked, and a long hold-off on request so the output
  // register and the sequencer fill and the input side stalls.
  // ---------------------------------------------------------------------------
  initial begin : speed_sink
    int unsigned hold, r;
    hold = 0;
    speed_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (park_len != 0) begin
        hold     = park_len;
        park_len = 0;
        n_parks++;
      end else if (hold == 0 && !sink_steady) begin
        r = $urandom_range(99);
        if (r < 15) hold = $urandom_range(3, 1);
        else if (r == 15) hold = $urandom_range(200, 20);
      end
      if (hold != 0) begin
        speed_if.ready <= 1'b0;
        hold--;
      end else begin
        speed_if.ready <= 1'b1;
      end
    end
  end

  // Result monitor: values sampled at the edge are the pre-edge ones.
  always @(posedge clk_i) begin
    speed_t got;
    if (rst_ni && speed_if.valid === 1'b1 && speed_if.ready === 1'b1) begin
      got.left  = speed_if.left_speed;
      got.right = speed_if.right_speed;
      sb.check_speed(got);
    end
  end

  // Watchdog: too long without any item moving on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (sonar_if.valid === 1'b1 && sonar_if.ready === 1'b1)
        || (speed_if.valid === 1'b1 && speed_if.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no item moved for %0d cycles, %0d speed items outstanding",
                 $time, quiet_cycles, sb.pending());
        $display("fuzzy_obstacle_avoidance_controller test failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    sb            = new();
    n_sonar       = 0;
    n_parks       = 0;
    quiet_cycles  = 0;
    park_len      = 0;
    source_steady = 1'b0;
    sink_steady   = 1'b0;
    sonar_if.valid             = 1'b0;
    sonar_if.left_range        = '0;
    sonar_if.front_left_range  = '0;
    sonar_if.front_right_range = '0;
    sonar_if.right_range       = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_LOW_FULL_EDGE;
    cfg_wdata_i = '0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items at the reset register values.
    // Fields: left, front left, front right, right.
    drive_sonar('{13'd1000, 13'd5000, 13'd5000, 13'd1000});  // no echo either side, front = 0
    drive_sonar('{13'd0,    13'd0,    13'd0,    13'd0});     // all zero
    drive_sonar('{13'd8191, 13'd8191, 13'd8191, 13'd8191});  // all max, fronts count as no echo
    drive_sonar('{13'd600,  13'd800,  13'd5000, 13'd600});   // only left front echoes
    drive_sonar('{13'd601,  13'd5000, 13'd1200, 13'd999});   // only right front echoes
    drive_sonar('{13'd1000, 13'd6000, 13'd300,  13'd1001});  // above-range front is no echo
    drive_sonar('{13'd1399, 13'd400,  13'd800,  13'd1400});  // exactly twice: left front wins
    drive_sonar('{13'd1401, 13'd900,  13'd450,  13'd5000});  // right front at half
    drive_sonar('{13'd5000, 13'd700,  13'd900,  13'd601});   // close readings: mean
    drive_sonar('{13'd4999, 13'd4999, 13'd4999, 13'd0});     // largest echo, mean
    drive_sonar('{13'd100,  13'd1,    13'd0,    13'd100});   // zero reading wins
    drive_sonar('{13'd2000, 13'd5000, 13'd5000, 13'd2000});  // no echo, keeps 0
    drive_sonar('{13'd700,  13'd600,  13'd5000, 13'd1300});  // breakpoints on the front
    drive_sonar('{13'd1300, 13'd1000, 13'd5000, 13'd700});
    drive_sonar('{13'd800,  13'd1400, 13'd5000, 13'd1200});
    drive_sonar('{13'd999,  13'd999,  13'd5000, 13'd1399});
    drive_sonar('{13'd1001, 13'd1001, 13'd5000, 13'd601});
    drive_sonar('{13'd4096, 13'd601,  13'd5000, 13'd4095});
    drive_sonar('{13'd2730, 13'd5461, 13'd2000, 13'd5461});
    drive_sonar('{13'd0,    13'd1399, 13'd2800, 13'd8191});  // just past twice: left front
    drive_sonar('{13'd8191, 13'd0,    13'd8191, 13'd0});
    random_sonar_batch(150);
    drain_speeds();

    for (int unsigned phase = 1; phase <= N_PHASES; phase++) begin
      apply_setting(phase);
      // Both sides steady for one whole set, idling everywhere else.
      source_steady = (phase == 2);
      sink_steady   = (phase == 2);
      // Long output hold-off while the sender keeps offering.
      if (phase == 1) park_len = PARK_CYCLES;
      if (phase == 4) begin
        // Front exactly at the peak with the HIGH full edge below it: no front
        // membership is nonzero, so no rule fires and both speeds must be zero.
        drive_sonar('{13'd1000, 13'd1000, 13'd1000, 13'd1000});
        drive_sonar('{13'd300,  13'd1000, 13'd5000, 13'd2000});
      end
      random_sonar_batch(BATCH);
      drain_speeds();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d sonar items over the reset values and %0d written register sets,",
             n_sonar, N_PHASES);
    $display("checked %0d speed items, %0d mismatches, %0d long output hold-off(s).",
             sb.n_checked, sb.n_errors, n_parks);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("fuzzy_obstacle_avoidance_controller test passed");
    end else begin
      $display("fuzzy_obstacle_avoidance_controller test failed");
    end
    $finish;
  end

endmodule

### filelist.f
sv/foac_pkg.sv
sv/foac_if.sv
sv/foac_div.sv
sv/fuzzy_obstacle_avoidance_controller.sv
sv/foac_checker.sv
sim/tb_fuzzy_obstacle_avoidance_controller.sv
